>>> hdl/gwm_pkg.sv
`timescale 1ns / 1ps

package gwm_pkg;

	localparam int PATTERN_TOKENS = 64;
	localparam int CNT_W = $clog2(PATTERN_TOKENS + 1);
	localparam int IDX_W = $clog2(PATTERN_TOKENS);
	localparam int CLOSE_LVL = $clog2(PATTERN_TOKENS + 1);

	localparam logic [1:0] KIND_CLEAR  = 2'd0;
	localparam logic [1:0] KIND_APPEND = 2'd1;
	localparam logic [1:0] KIND_SUBJ   = 2'd2;
	localparam logic [1:0] KIND_END    = 2'd3;

	localparam logic [7:0] CHR_STAR    = 8'h2A;
	localparam logic [7:0] CHR_QMARK   = 8'h3F;
	localparam logic [7:0] CHR_BSLASH  = 8'h5C;
	localparam logic [7:0] CHR_UPPER_A = 8'h41;
	localparam logic [7:0] CHR_UPPER_Z = 8'h5A;
	localparam logic [7:0] CASE_OFFSET = 8'h20;

	typedef enum logic [1:0] {
		TOK_LIT = 2'd0,
		TOK_ONE = 2'd1,
		TOK_RUN = 2'd2
	} tok_t;

	typedef logic [PATTERN_TOKENS:0]   pos_vec_t;
	typedef logic [PATTERN_TOKENS-1:0] tok_vec_t;

	typedef struct packed {
		logic       restart;
		logic       step;
		logic [7:0] sym;
	} nfa_ctl_t;

	function automatic logic [7:0] fold_byte(input logic [7:0] b);
		logic [7:0] r;
		r = b;
		if (b >= CHR_UPPER_A && b <= CHR_UPPER_Z) begin
			r = b + CASE_OFFSET;
		end
		return r;
	endfunction

	// Spreads active positions forward across chains of any-run tokens.
	// This is a carry chain (generate = base, propagate = link into the
	// next position), so it is evaluated as a parallel prefix.
	function automatic pos_vec_t close_runs(input pos_vec_t base, input tok_vec_t link);
		pos_vec_t g;
		pos_vec_t p;
		pos_vec_t g_n;
		pos_vec_t p_n;
		g = base;
		p = {link, 1'b0};
		for (int l = 0; l < CLOSE_LVL; l++) begin
			g_n = g;
			p_n = p;
			for (int j = 0; j <= PATTERN_TOKENS; j++) begin
				if (j >= (1 << l)) begin
					g_n[j] = g[j] | (p[j] & g[j - (1 << l)]);
					p_n[j] = p[j] & p[j - (1 << l)];
				end
			end
			g = g_n;
			p = p_n;
		end
		return g;
	endfunction

endpackage

>>> hdl/gwm_nfa.sv
`timescale 1ns / 1ps

module gwm_nfa (
	input  gwm_pkg::nfa_ctl_t ctl,
	input  gwm_pkg::pos_vec_t act,
	input  gwm_pkg::tok_vec_t run_vec,
	input  gwm_pkg::tok_vec_t one_vec,
	input  gwm_pkg::tok_vec_t live,
	input  logic [7:0]        lit [gwm_pkg::PATTERN_TOKENS],
	output gwm_pkg::pos_vec_t act_next
);
	import gwm_pkg::*;

	pos_vec_t base;

	always_comb begin
		base = '0;
		if (ctl.step) begin
			for (int i = 0; i < PATTERN_TOKENS; i++) begin
				if (act[i] && live[i]) begin
					if (run_vec[i]) begin
						base[i] = 1'b1;
					end else if (one_vec[i] || lit[i] == ctl.sym) begin
						base[i + 1] = 1'b1;
					end
				end
			end
		end else if (ctl.restart) begin
			base[0] = 1'b1;
		end else begin
			base = act;
		end
	end

	assign act_next = close_runs(base, run_vec & live);

endmodule

>>> hdl/glob_wildcard_matcher_unit.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake              Words
// in        input      in_valid / in_stall    kind, byte_value
// out       output     out_valid / out_stall  matched, pattern_overflow
//
// One input word per cycle while in_stall is low; a word is held in the input register and
// the whole automaton update over all pattern positions is computed combinationally.
// An end-of-subject word passes the input register, then its result is loaded into the result register.
// in_stall rises only when an end-of-subject word waits behind a stalled result.
// arst_n clears the pattern, the escape and overflow flags and the subject.
module glob_wildcard_matcher_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] kind,
	input  logic [7:0] byte_value,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       matched,
	output logic       pattern_overflow
);
	import gwm_pkg::*;

	logic       valid_s1;
	logic [1:0] kind_s1;
	logic [7:0] byte_s1;

	tok_t       type_q [PATTERN_TOKENS];
	logic [7:0] lit_q  [PATTERN_TOKENS];
	logic [CNT_W-1:0] cnt_q;
	logic       esc_q;
	logic       ovf_q;
	pos_vec_t   act_q;

	logic       out_valid_q;
	logic       matched_q;
	logic       ovf_out_q;

	logic       fire;
	logic       is_bslash;
	logic       esc_start;
	logic       room;
	logic       app;
	logic       wr;
	logic [IDX_W-1:0] widx;
	tok_t       new_type;
	logic [7:0] new_lit;
	logic [CNT_W-1:0] cnt_d;
	tok_vec_t   run_d;
	tok_vec_t   one_d;
	tok_vec_t   live_d;
	logic [7:0] lit_d [PATTERN_TOKENS];
	nfa_ctl_t   ctl;
	pos_vec_t   act_next;

	// An end word needs the result register; everything else always proceeds.
	assign fire = valid_s1 && (kind_s1 != KIND_END || !out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !fire;

	always_comb begin
		is_bslash = byte_s1 == CHR_BSLASH;
		esc_start = !esc_q && is_bslash;
		room = cnt_q < CNT_W'(PATTERN_TOKENS);
		app = fire && kind_s1 == KIND_APPEND && !esc_start;
		wr = app && room;
		widx = cnt_q[IDX_W-1:0];

		new_type = TOK_LIT;
		new_lit = fold_byte(byte_s1);
		if (!esc_q) begin
			if (byte_s1 == CHR_STAR) begin
				new_type = TOK_RUN;
				new_lit = '0;
			end else if (byte_s1 == CHR_QMARK) begin
				new_type = TOK_ONE;
				new_lit = '0;
			end
		end

		cnt_d = cnt_q;
		if (fire && kind_s1 == KIND_CLEAR) begin
			cnt_d = '0;
		end else if (wr) begin
			cnt_d = cnt_q + CNT_W'(1);
		end

		// The token being written takes part in this cycle's restart closure.
		for (int i = 0; i < PATTERN_TOKENS; i++) begin
			if (wr && widx == IDX_W'(i)) begin
				run_d[i] = new_type == TOK_RUN;
				one_d[i] = new_type == TOK_ONE;
				lit_d[i] = new_lit;
			end else begin
				run_d[i] = type_q[i] == TOK_RUN;
				one_d[i] = type_q[i] == TOK_ONE;
				lit_d[i] = lit_q[i];
			end
			live_d[i] = CNT_W'(i) < cnt_d;
		end

		ctl.restart = fire && kind_s1 != KIND_SUBJ;
		ctl.step = fire && kind_s1 == KIND_SUBJ;
		ctl.sym = fold_byte(byte_s1);
	end

	gwm_nfa u_nfa (
		.ctl      (ctl),
		.act      (act_q),
		.run_vec  (run_d),
		.one_vec  (one_d),
		.live     (live_d),
		.lit      (lit_d),
		.act_next (act_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			cnt_q <= '0;
			esc_q <= 1'b0;
			ovf_q <= 1'b0;
			act_q <= pos_vec_t'(1);
			out_valid_q <= 1'b0;
		end else begin
			if (!in_stall) begin
				valid_s1 <= in_valid;
			end
			if (fire) begin
				cnt_q <= cnt_d;
				act_q <= act_next;
				case (kind_s1)
					KIND_CLEAR: begin
						esc_q <= 1'b0;
						ovf_q <= 1'b0;
					end
					KIND_APPEND: begin
						esc_q <= esc_start;
						if (app && !room) begin
							ovf_q <= 1'b1;
						end
					end
					default: begin
					end
				endcase
			end
			if (fire && kind_s1 == KIND_END) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			kind_s1 <= kind;
			byte_s1 <= byte_value;
		end
		if (wr) begin
			type_q[widx] <= new_type;
			lit_q[widx] <= new_lit;
		end
		if (fire && kind_s1 == KIND_END) begin
			matched_q <= act_q[cnt_q];
			ovf_out_q <= ovf_q;
		end
	end

	assign out_valid = out_valid_q;
	assign matched = matched_q;
	assign pattern_overflow = ovf_out_q;

endmodule

>>> hdl/gwm_checker.sv
`timescale 1ns / 1ps

module gwm_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic [1:0] kind,
	input logic [7:0] byte_value,
	input logic       out_valid,
	input logic       out_stall,
	input logic       matched,
	input logic       pattern_overflow
);
	import gwm_pkg::*;

	logic in_acc;
	assign in_acc = in_valid && !in_stall;

	// A stalled result word holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(matched) && $stable(pattern_overflow))
		else $error("result word changed while stalled");

	// Input backpressure comes only from a stalled result.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without a stalled result");

	// A fresh result traces back to an accepted end word.
	a_result_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_acc && kind == KIND_END, 2))
		else $error("result word without a matching end word");

	// An empty pattern matches an empty subject.
	a_empty_match: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && kind == KIND_CLEAR ##1 in_acc && kind == KIND_END
		##1 (!out_valid || !out_stall)
		|=> out_valid && matched && !pattern_overflow)
		else $error("empty pattern did not match empty subject");

endmodule

bind glob_wildcard_matcher_unit gwm_checker u_gwm_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.in_valid         (in_valid),
	.in_stall         (in_stall),
	.kind             (kind),
	.byte_value       (byte_value),
	.out_valid        (out_valid),
	.out_stall        (out_stall),
	.matched          (matched),
	.pattern_overflow (pattern_overflow)
);
